// ===== rtl/core/sfd_pkg.sv =====
// Shared types and constants for the stuffed frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfd_pkg;

    // Largest frame in bytes, LEN byte included
    localparam int MAX_FRAME_BYTES = 256;
    localparam logic [8:0] MAX_POS = 9'(MAX_FRAME_BYTES);

    // CRC-32, MSB first, no final xor
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Minimum legal LEN value: TYPE plus four CRC bytes
    localparam logic [7:0] MIN_LEN = 8'd5;

    // Configuration register indexes
    localparam logic [7:0] REG_MARKER     = 8'd0;
    localparam logic [7:0] REG_ESCAPE     = 8'd1;
    localparam logic [7:0] REG_ESC_MARKER = 8'd2;
    localparam logic [7:0] REG_ESC_ESCAPE = 8'd3;

    // Configuration reset values
    localparam logic [7:0] MARKER_RST     = 8'd126;
    localparam logic [7:0] ESCAPE_RST     = 8'd125;
    localparam logic [7:0] ESC_MARKER_RST = 8'd94;
    localparam logic [7:0] ESC_ESCAPE_RST = 8'd93;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_GOOD      = 2'd1;
    localparam logic [1:0] KIND_CRC_ERR   = 2'd2;
    localparam logic [1:0] KIND_SYNC_LOSS = 2'd3;

    typedef struct packed {
        logic [7:0] marker;
        logic [7:0] escape;
        logic [7:0] esc_marker;
        logic [7:0] esc_escape;
    } cfg_t;

    // Line event after escape removal
    typedef struct packed {
        logic       restart;     // unescaped marker
        logic       esc_err;     // escape followed by an unknown code
        logic       data_valid;  // decoded byte for the parser
        logic [7:0] data;
    } event_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_type;
        logic [7:0]  payload_length;
        logic [15:0] sync_loss_total;
        logic [15:0] crc_error_total;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfd_unstuff.sv =====
// Escape removal: turns raw line bytes into restart, error and data events.
// Depends on sfd_pkg.
`default_nettype none

module sfd_unstuff (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    line_byte,
    input  wire sfd_pkg::cfg_t cfg,
    output sfd_pkg::event_t    ev
);
    import sfd_pkg::*;

    logic esc_pending_reg;
    logic esc_pending_next;
    logic is_marker;

    assign is_marker = (line_byte == cfg.marker) && !esc_pending_reg;

    // Classify the byte; an unescaped marker match takes priority over everything
    always_comb
    begin
        ev = '0;
        ev.data = line_byte;
        esc_pending_next = 1'b0;
        if (is_marker)
        begin
            ev.restart = 1'b1;
        end
        else if (esc_pending_reg)
        begin
            // equal codes: marker meaning wins
            if (line_byte == cfg.esc_marker)
            begin
                ev.data_valid = 1'b1;
                ev.data = cfg.marker;
            end
            else if (line_byte == cfg.esc_escape)
            begin
                ev.data_valid = 1'b1;
                ev.data = cfg.escape;
            end
            else
            begin
                ev.esc_err = 1'b1;
            end
        end
        else if (line_byte == cfg.escape)
        begin
            esc_pending_next = 1'b1;
        end
        else
        begin
            ev.data_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_pending_reg <= 1'b0;
        end
        else if (step)
        begin
            esc_pending_reg <= esc_pending_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfd_parser.sv =====
// Frame parser: LEN/TYPE/payload/CRC sequencing, CRC-32 check, counters.
// Depends on sfd_pkg; fed by sfd_unstuff events.
`default_nettype none

module sfd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      marker,
    input  wire sfd_pkg::event_t ev,
    output logic                 res_valid,
    output sfd_pkg::result_t     res
);
    import sfd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SPARE = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rx_crc_reg, rx_crc_next;
    logic [15:0] sl_cnt_reg, sl_cnt_next;
    logic [15:0] ce_cnt_reg, ce_cnt_next;

    logic [7:0]  plen;
    logic [1:0]  pad;
    logic [1:0]  crc_slot;
    logic [31:0] rx_crc_shift;
    logic        sl_hit;
    logic        ce_hit;

    // One byte through the CRC register, MSB first
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int i = 0; i < 8; i++)
        begin
            if (c[31])
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[30:0], 1'b0};
        end
        return c;
    endfunction

    assign plen = len_reg - MIN_LEN;
    // zero bytes needed to pad LEN..payload (LEN - 3 bytes) to a multiple of 4
    assign pad = 2'(2'd3 - len_reg[1:0]);
    // which of the four CRC bytes this is
    assign crc_slot = 2'(pos_reg[1:0] + 2'd3 - len_reg[1:0]);
    assign rx_crc_shift = {ev.data, rx_crc_reg[31:8]};

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        type_next   = type_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        sl_hit      = 1'b0;
        ce_hit      = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        res.kind    = KIND_SYNC_LOSS;

        if (ev.restart)
        begin
            // marker mid-frame is a sync loss
            if (phase_reg == PH_DATA)
            begin
                sl_hit    = 1'b1;
                res_valid = 1'b1;
            end
            phase_next  = PH_LEN;
            pos_next    = '0;
            crc_next    = CRC_INIT;
            rx_crc_next = '0;
        end
        else if (ev.esc_err)
        begin
            sl_hit     = 1'b1;
            res_valid  = 1'b1;
            phase_next = PH_IDLE;
            pos_next   = '0;
            len_next   = '0;
        end
        else if (ev.data_valid)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    // decoded marker starts a frame
                    if (ev.data == marker)
                    begin
                        phase_next  = PH_LEN;
                        pos_next    = '0;
                        crc_next    = CRC_INIT;
                        rx_crc_next = '0;
                    end
                end
                PH_LEN:
                begin
                    if ((ev.data < MIN_LEN) || ({1'b0, ev.data} >= MAX_POS))
                    begin
                        sl_hit     = 1'b1;
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                        pos_next   = '0;
                        len_next   = '0;
                    end
                    else
                    begin
                        len_next    = ev.data;
                        pos_next    = 9'd1;
                        crc_next    = crc_update(CRC_INIT, ev.data);
                        rx_crc_next = '0;
                        phase_next  = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (pos_reg >= MAX_POS)
                    begin
                        sl_hit     = 1'b1;
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                        pos_next   = '0;
                        len_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 9'd1;
                        if (pos_reg == 9'd1)
                        begin
                            type_next = ev.data;
                            crc_next  = crc_update(crc_reg, ev.data);
                        end
                        else if ((pos_reg + 9'd4) <= {1'b0, len_reg})
                        begin
                            // payload beat
                            crc_next          = crc_update(crc_reg, ev.data);
                            res_valid         = 1'b1;
                            res.kind          = KIND_PAYLOAD;
                            res.payload_byte  = ev.data;
                            res.payload_index = 8'(pos_reg - 9'd2);
                            res.frame_type    = type_reg;
                            res.payload_length = plen;
                        end
                        else
                        begin
                            rx_crc_next = rx_crc_shift;
                            if (pos_reg >= {1'b0, len_reg})
                            begin
                                // last CRC byte: padding already folded in
                                res_valid          = 1'b1;
                                res.frame_type     = type_reg;
                                res.payload_length = plen;
                                phase_next = PH_IDLE;
                                pos_next   = '0;
                                len_next   = '0;
                                if (crc_reg == rx_crc_shift)
                                begin
                                    res.kind = KIND_GOOD;
                                end
                                else
                                begin
                                    res.kind = KIND_CRC_ERR;
                                    ce_hit   = 1'b1;
                                end
                            end
                            else if (crc_slot < pad)
                            begin
                                // one zero pad byte per CRC byte
                                crc_next = crc_update(crc_reg, 8'h00);
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        sl_cnt_next = (sl_hit && (sl_cnt_reg != 16'hFFFF)) ? sl_cnt_reg + 16'd1 : sl_cnt_reg;
        ce_cnt_next = (ce_hit && (ce_cnt_reg != 16'hFFFF)) ? ce_cnt_reg + 16'd1 : ce_cnt_reg;
        res.sync_loss_total = sl_cnt_next;
        res.crc_error_total = ce_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            len_reg    <= '0;
            pos_reg    <= '0;
            type_reg   <= '0;
            crc_reg    <= CRC_INIT;
            rx_crc_reg <= '0;
            sl_cnt_reg <= '0;
            ce_cnt_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            type_reg   <= type_next;
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
            sl_cnt_reg <= sl_cnt_next;
            ce_cnt_reg <= ce_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfd_result_reg.sv =====
// Output register for result beats with valid/ready handshake.
// Depends on sfd_pkg.
`default_nettype none

module sfd_result_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire sfd_pkg::result_t res,
    output logic                  slot_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sfd_pkg::result_t      out_res
);
    import sfd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // slot frees when empty or when the held beat leaves this cycle
    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stuffed_frame_deframer_crc32.sv =====
// Byte-stuffed frame deframer with CRC-32 check, one line byte per beat.
// Path: an accepted byte waits in the input register; once the result slot is free, any
// result it yields goes through unstuff and parser into the result register (out_valid).
// Throughput: one byte per cycle, set by the combinational byte CRC update; a result
// held by a low out_ready stalls the input once a second byte is waiting.
// Reset: parser state, counters and escape flag clear; config registers
// return to their defaults. No clearing pass.
`default_nettype none

module stuffed_frame_deframer_crc32 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [7:0]       payload_byte,
    output logic [7:0]       payload_index,
    output logic [7:0]       frame_type,
    output logic [7:0]       payload_length,
    output logic [15:0]      sync_loss_total,
    output logic [15:0]      crc_error_total
);
    import sfd_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       step;
    logic       slot_free;
    logic       res_valid;
    event_t     ev;
    result_t    res;
    result_t    out_res;

    // Configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.marker     <= MARKER_RST;
            cfg_reg.escape     <= ESCAPE_RST;
            cfg_reg.esc_marker <= ESC_MARKER_RST;
            cfg_reg.esc_escape <= ESC_ESCAPE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MARKER:     cfg_reg.marker     <= cfg_data;
                REG_ESCAPE:     cfg_reg.escape     <= cfg_data;
                REG_ESC_MARKER: cfg_reg.esc_marker <= cfg_data;
                REG_ESC_ESCAPE: cfg_reg.esc_escape <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Input register; the held byte is processed once the result slot is free
    assign step     = in_valid_reg && slot_free;
    assign in_ready = !in_valid_reg || slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    sfd_unstuff u_unstuff (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .line_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .ev        (ev)
    );

    sfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .marker    (cfg_reg.marker),
        .ev        (ev),
        .res_valid (res_valid),
        .res       (res)
    );

    sfd_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign result_kind     = out_res.kind;
    assign payload_byte    = out_res.payload_byte;
    assign payload_index   = out_res.payload_index;
    assign frame_type      = out_res.frame_type;
    assign payload_length  = out_res.payload_length;
    assign sync_loss_total = out_res.sync_loss_total;
    assign crc_error_total = out_res.crc_error_total;

endmodule

`default_nettype wire
